// File: rtl/palette_to_uyvy_pixel_packer_defines.svh
// Assertion macros for the palette packer.
`ifndef PALETTE_TO_UYVY_PIXEL_PACKER_DEFINES_SVH
`define PALETTE_TO_UYVY_PIXEL_PACKER_DEFINES_SVH

`ifndef SYNTHESIS

// Condition in this cycle implies a consequence in the same cycle
`define P2UYVY_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("p2uyvy: same-cycle check failed");

// Condition in this cycle implies a consequence in the next cycle
`define P2UYVY_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("p2uyvy: next-cycle check failed");

`else

`define P2UYVY_ASSERT_SAME(label, clk, rst_n, cond, cons)
`define P2UYVY_ASSERT_NEXT(label, clk, rst_n, cond, cons)

`endif

`endif

// File: rtl/p2uyvy_pkg.sv
`default_nettype none

package p2uyvy_pkg;

    // Number of palette entries and the index width they need
    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W           = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    // One palette entry: luma plus two's complement chroma patterns
    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] cb;
        logic [7:0] cr;
    } ycc_t;

    // Write request into the palette memory
    typedef struct packed {
        logic       en;
        logic [7:0] slot;
        ycc_t       data;
    } pal_wr_t;

    // Read request for a pixel pair
    typedef struct packed {
        logic       en;
        logic [7:0] addr_first;
        logic [7:0] addr_second;
    } pal_rd_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHROMA,
        ST_AVG
    } state_t;

endpackage

`default_nettype wire

// File: rtl/p2uyvy_mem.sv
`default_nettype none

module p2uyvy_mem (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire p2uyvy_pkg::pal_wr_t wr,
    input  wire p2uyvy_pkg::pal_rd_t rd,
    output p2uyvy_pkg::ycc_t       rd_first,
    output p2uyvy_pkg::ycc_t       rd_second
);
    import p2uyvy_pkg::*;

    localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

    ycc_t                       mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] valid_reg;
    ycc_t                       first_data_reg;
    ycc_t                       second_data_reg;
    logic                       first_hit_reg;
    logic                       second_hit_reg;

    logic             wr_ok;
    logic             first_ok;
    logic             second_ok;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] first_idx;
    logic [IDX_W-1:0] second_idx;

    // Range checks: slots past the palette are dropped or read as zero
    assign wr_ok      = ({1'b0, wr.slot} < PAL_LIMIT);
    assign first_ok   = ({1'b0, rd.addr_first} < PAL_LIMIT);
    assign second_ok  = ({1'b0, rd.addr_second} < PAL_LIMIT);
    assign wr_idx     = wr.slot[IDX_W-1:0];
    assign first_idx  = rd.addr_first[IDX_W-1:0];
    assign second_idx = rd.addr_second[IDX_W-1:0];

    // Write port and registered read ports
    always_ff @(posedge clk)
    begin
        if (wr.en && wr_ok)
        begin
            mem[wr_idx] <= wr.data;
        end
        if (rd.en)
        begin
            first_data_reg  <= mem[first_idx];
            second_data_reg <= mem[second_idx];
        end
    end

    // Per-entry valid bits give the all-zero reset image
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            first_hit_reg  <= 1'b0;
            second_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr.en && wr_ok)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd.en)
            begin
                first_hit_reg  <= first_ok && valid_reg[first_idx];
                second_hit_reg <= second_ok && valid_reg[second_idx];
            end
        end
    end

    // Unwritten or out-of-range entries read as zero
    assign rd_first  = first_hit_reg  ? first_data_reg  : '0;
    assign rd_second = second_hit_reg ? second_data_reg : '0;

endmodule

`default_nettype wire

// File: rtl/p2uyvy_csc.sv
`default_nettype none

module p2uyvy_csc (
    input  wire logic       clk,
    input  wire logic       load,
    input  wire logic [7:0] red,
    input  wire logic [7:0] green,
    input  wire logic [7:0] blue,
    output p2uyvy_pkg::ycc_t entry
);
    import p2uyvy_pkg::*;

    logic [7:0] luma_reg;
    logic [7:0] red_reg;
    logic [7:0] blue_reg;

    logic [15:0]        luma_sum;
    logic signed [9:0]  b_diff;
    logic signed [9:0]  r_diff;
    logic signed [17:0] b_prod;
    logic signed [17:0] r_prod;

    // Clamp a scaled chroma value to -128..127
    function automatic logic [7:0] sat8(input logic signed [9:0] x);
        logic [7:0] res;
        if (x > 10'sd127)
        begin
            res = 8'h7F;
        end
        else if (x < -10'sd128)
        begin
            res = 8'h80;
        end
        else
        begin
            res = x[7:0];
        end
        return res;
    endfunction

    // Stage one: weighted luma sum
    assign luma_sum = 16'(red) * 16'd77 + 16'(green) * 16'd150 + 16'(blue) * 16'd29;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            luma_reg <= luma_sum[15:8];
            red_reg  <= red;
            blue_reg <= blue;
        end
    end

    // Stage two: scaled color differences, floor shift, saturate
    assign b_diff = $signed({2'b00, blue_reg}) - $signed({2'b00, luma_reg});
    assign r_diff = $signed({2'b00, red_reg}) - $signed({2'b00, luma_reg});
    assign b_prod = 18'(b_diff) * 18'sd144;
    assign r_prod = 18'(r_diff) * 18'sd183;

    assign entry.luma = luma_reg;
    assign entry.cb   = sat8(b_prod[17:8]);
    assign entry.cr   = sat8(r_prod[17:8]);

endmodule

`default_nettype wire

// File: rtl/palette_to_uyvy_pixel_packer.sv
// Palette-to-UYVY pixel packer. A request with command 0 converts red, green
// and blue to luma and saturated chroma and stores them in a 256-entry
// palette; it gives no result. A request with command 1 looks up two palette
// indices and returns one UYVY group (averaged U, left Y, averaged V, right Y).
// Each request is taken in the idle state and finished in a second state: a
// palette write registers the luma sum, then does the chroma multiply and
// memory write; a pixel pair does the registered palette read, then averages
// into the output register. A pixel pair stays in the averaging state, with the
// input blocked, for as long as an earlier group still waits at the output.
// Otherwise the next request is taken while a result still waits at the
// output. The palette reads as all zero after reset through per-entry
// valid bits, so no clearing pass is needed.
`default_nettype none

module palette_to_uyvy_pixel_packer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       command,
    input  wire logic [7:0] palette_slot,
    input  wire logic [7:0] red,
    input  wire logic [7:0] green,
    input  wire logic [7:0] blue,
    input  wire logic [7:0] first_pixel,
    input  wire logic [7:0] second_pixel,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      u_byte,
    output logic [7:0]      luma_first,
    output logic [7:0]      v_byte,
    output logic [7:0]      luma_second
);
    import p2uyvy_pkg::*;

`include "palette_to_uyvy_pixel_packer_defines.svh"

    state_t     state_reg;
    state_t     state_next;
    logic [7:0] slot_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] u_byte_reg;
    logic [7:0] luma_first_reg;
    logic [7:0] v_byte_reg;
    logic [7:0] luma_second_reg;

    logic    accept;
    logic    load_out;
    logic    wr_en;
    logic    csc_load;
    ycc_t    csc_entry;
    pal_wr_t wr;
    pal_rd_t rd;
    ycc_t    rd_first;
    ycc_t    rd_second;
    logic [8:0] u_sum;
    logic [8:0] v_sum;

    assign accept = in_valid && in_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = command ? ST_AVG : ST_CHROMA;
                end
            end
            ST_CHROMA:
            begin
                state_next = ST_IDLE;
            end
            ST_AVG:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        load_out = 1'b0;
        wr_en    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_CHROMA:
            begin
                wr_en = 1'b1;
            end
            ST_AVG:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Palette write and pixel pair read requests
    assign csc_load       = accept && !command;
    assign wr.en          = wr_en;
    assign wr.slot        = slot_reg;
    assign wr.data        = csc_entry;
    assign rd.en          = accept && command;
    assign rd.addr_first  = first_pixel;
    assign rd.addr_second = second_pixel;

    p2uyvy_csc u_csc (
        .clk   (clk),
        .load  (csc_load),
        .red   (red),
        .green (green),
        .blue  (blue),
        .entry (csc_entry)
    );

    p2uyvy_mem u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .rd        (rd),
        .rd_first  (rd_first),
        .rd_second (rd_second)
    );

    // Floor average of the two chroma values
    assign u_sum = {rd_first.cb[7], rd_first.cb} + {rd_second.cb[7], rd_second.cb};
    assign v_sum = {rd_first.cr[7], rd_first.cr} + {rd_second.cr[7], rd_second.cr};

    // Hold output until taken, then advance
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (csc_load)
        begin
            slot_reg <= palette_slot;
        end
        if (load_out)
        begin
            u_byte_reg      <= u_sum[8:1];
            luma_first_reg  <= rd_first.luma;
            v_byte_reg      <= v_sum[8:1];
            luma_second_reg <= rd_second.luma;
        end
    end

    assign out_valid   = out_valid_reg;
    assign u_byte      = u_byte_reg;
    assign luma_first  = luma_first_reg;
    assign v_byte      = v_byte_reg;
    assign luma_second = luma_second_reg;

    // A pixel pair moves to averaging, a palette write to the chroma stage
    `P2UYVY_ASSERT_NEXT(a_pair_to_avg, clk, rst_n, accept && command, state_reg == ST_AVG)
    `P2UYVY_ASSERT_NEXT(a_write_to_chroma, clk, rst_n, accept && !command, wr.en)
    // Never read the palette in the cycle it is written
    `P2UYVY_ASSERT_SAME(a_no_rd_on_wr, clk, rst_n, wr.en, !rd.en)

endmodule

`default_nettype wire

// File: bench/palette_to_uyvy_pixel_packer_tb.sv
`default_nettype none

module palette_to_uyvy_pixel_packer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import p2uyvy_pkg::*;

    localparam logic CMD_PALETTE_WRITE = 1'b0;
    localparam logic CMD_PIXEL_PAIR    = 1'b1;

    localparam int RANDOM_REQUESTS = 900;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLDOFF_CYCLES  = 150;
    localparam int HOLDOFF_AFTER   = 400;
    localparam int DRAIN_CYCLES    = 16;
    localparam int DIRECTED_ROWS   = 24;

    // One UYVY group as it leaves the block
    typedef struct packed {
        logic [7:0] u;
        logic [7:0] y0;
        logic [7:0] v;
        logic [7:0] y1;
    } uyvy_group_t;

    // One request, plus an optional hand-typed group
    typedef struct packed {
        logic        cmd;
        logic [7:0]  slot;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  p0;
        logic [7:0]  p1;
        logic        typed;
        uyvy_group_t group;
    } request_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic       command;
    logic [7:0] palette_slot;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] first_pixel;
    logic [7:0] second_pixel;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] u_byte;
    logic [7:0] luma_first;
    logic [7:0] v_byte;
    logic [7:0] luma_second;

    // Typed group that travels with the request on the input port
    logic        row_typed;
    uyvy_group_t row_group;

    // Shadow palette
    logic [7:0] pal_luma [256];
    logic [7:0] pal_cb   [256];
    logic [7:0] pal_cr   [256];

    uyvy_group_t groups_due [$];
    uyvy_group_t oldest_group;
    int          mismatches     = 0;
    int          requests_taken = 0;
    int          burst_left     = 0;

    request_t directed_rows [DIRECTED_ROWS] = '{
        '{CMD_PIXEL_PAIR,    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
          '{8'h00, 8'h00, 8'h00, 8'h00}},
        '{CMD_PIXEL_PAIR,    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1,
          '{8'h00, 8'h00, 8'h00, 8'h00}},
        '{CMD_PALETTE_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0, '0},
        '{CMD_PIXEL_PAIR,    8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 1'b1,
          '{8'h00, 8'hFF, 8'h00, 8'h00}},
        '{CMD_PALETTE_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0, '0},
        '{CMD_PALETTE_WRITE, 8'h01, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 1'b0, '0},
        '{CMD_PALETTE_WRITE, 8'h02, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
        '{CMD_PALETTE_WRITE, 8'h03, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, '0},
        '{CMD_PALETTE_WRITE, 8'h04, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, '0},
        '{CMD_PALETTE_WRITE, 8'h05, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0, '0},
        '{CMD_PIXEL_PAIR,    8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 1'b0, '0},
        '{CMD_PIXEL_PAIR,    8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 1'b0, '0},
        '{CMD_PIXEL_PAIR,    8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h01, 1'b0, '0},
        '{CMD_PIXEL_PAIR,    8'h00, 8'h00, 8'h00, 8'h00, 8'h04, 8'h01, 1'b0, '0},
        '{CMD_PIXEL_PAIR,    8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h02, 1'b0, '0},
        '{CMD_PIXEL_PAIR,    8'h00, 8'h00, 8'h00, 8'h00, 8'h04, 8'h04, 1'b0, '0},
        '{CMD_PIXEL_PAIR,    8'h00, 8'h00, 8'h00, 8'h00, 8'h03, 8'h05, 1'b0, '0},
        '{CMD_PIXEL_PAIR,    8'h00, 8'h00, 8'h00, 8'h00, 8'hC8, 8'h03, 1'b0, '0},
        '{CMD_PALETTE_WRITE, 8'h01, 8'h80, 8'h40, 8'h20, 8'h00, 8'h00, 1'b0, '0},
        '{CMD_PIXEL_PAIR,    8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 1'b0, '0},
        '{CMD_PALETTE_WRITE, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
        '{CMD_PIXEL_PAIR,    8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 1'b1,
          '{8'h00, 8'h00, 8'h00, 8'h00}},
        '{CMD_PALETTE_WRITE, 8'h80, 8'h11, 8'hC8, 8'h63, 8'h00, 8'h00, 1'b0, '0},
        '{CMD_PIXEL_PAIR,    8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h03, 1'b0, '0}
    };

    palette_to_uyvy_pixel_packer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .palette_slot (palette_slot),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .first_pixel  (first_pixel),
        .second_pixel (second_pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .u_byte       (u_byte),
        .luma_first   (luma_first),
        .v_byte       (v_byte),
        .luma_second  (luma_second)
    );

    always #4 clk = ~clk;

    // Update the shadow palette or queue the group a pixel pair should give
    task automatic apply_request(input request_t req);
        int          y;
        int          cb;
        int          cr;
        int          cb_sum;
        int          cr_sum;
        logic [7:0]  y0;
        logic [7:0]  y1;
        logic [7:0]  cb0;
        logic [7:0]  cb1;
        logic [7:0]  cr0;
        logic [7:0]  cr1;
        uyvy_group_t grp;
        if (req.cmd == CMD_PALETTE_WRITE)
        begin
            // Drop writes past the end of the palette
            if (int'(req.slot) < PALETTE_ENTRIES)
            begin
                y  = (77 * int'(req.r) + 150 * int'(req.g) + 29 * int'(req.b)) >>> 8;
                y  = (y < 0) ? 0 : ((y > 255) ? 255 : y);
                cb = ((int'(req.b) - y) * 144) >>> 8;
                cr = ((int'(req.r) - y) * 183) >>> 8;
                cb = (cb < -128) ? -128 : ((cb > 127) ? 127 : cb);
                cr = (cr < -128) ? -128 : ((cr > 127) ? 127 : cr);
                pal_luma[req.slot] = y[7:0];
                pal_cb[req.slot]   = cb[7:0];
                pal_cr[req.slot]   = cr[7:0];
            end
        end
        else
        begin
            // Indexes past the end of the palette read as black
            {y0, cb0, cr0} = '0;
            {y1, cb1, cr1} = '0;
            if (int'(req.p0) < PALETTE_ENTRIES)
            begin
                y0  = pal_luma[req.p0];
                cb0 = pal_cb[req.p0];
                cr0 = pal_cr[req.p0];
            end
            if (int'(req.p1) < PALETTE_ENTRIES)
            begin
                y1  = pal_luma[req.p1];
                cb1 = pal_cb[req.p1];
                cr1 = pal_cr[req.p1];
            end
            cb_sum = (int'($signed(cb0)) + int'($signed(cb1))) >>> 1;
            cr_sum = (int'($signed(cr0)) + int'($signed(cr1))) >>> 1;
            grp.u  = cb_sum[7:0];
            grp.y0 = y0;
            grp.v  = cr_sum[7:0];
            grp.y1 = y1;
            groups_due.push_back(req.typed ? req.group : grp);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s mismatch, expected %02h, actual %02h",
                     $time, name, want, got);
        end
    endtask

    // Offer one request in bursts separated by random gaps, hold until taken
    task automatic send_request(input request_t req);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid     <= 1'b1;
        command      <= req.cmd;
        palette_slot <= req.slot;
        red          <= req.r;
        green        <= req.g;
        blue         <= req.b;
        first_pixel  <= req.p0;
        second_pixel <= req.p1;
        row_typed    <= req.typed;
        row_group    <= req.group;
        do @(posedge clk); while (!in_ready);
    endtask

    // Check outgoing groups, then predict from the request taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (groups_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: group with nothing expected, actual %02h %02h %02h %02h",
                             $time, u_byte, luma_first, v_byte, luma_second);
                end
                else
                begin
                    oldest_group = groups_due.pop_front();
                    check_field("u_byte",      oldest_group.u,  u_byte);
                    check_field("luma_first",  oldest_group.y0, luma_first);
                    check_field("v_byte",      oldest_group.v,  v_byte);
                    check_field("luma_second", oldest_group.y1, luma_second);
                end
            end
            if (in_valid && in_ready)
            begin
                requests_taken++;
                apply_request('{command, palette_slot, red, green, blue,
                                first_pixel, second_pixel, row_typed, row_group});
            end
        end
    end

    // Receiver: switch between stall patterns, with one long hold-off
    initial
    begin
        int  mode;
        int  mode_left;
        bit  holdoff_done;
        mode         = 0;
        mode_left    = 0;
        holdoff_done = 1'b0;
        out_ready    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!holdoff_done && requests_taken >= HOLDOFF_AFTER)
            begin
                out_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES - 1) @(negedge clk);
                holdoff_done = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(8, 80);
                end
                mode_left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        request_t req;
        for (int i = 0; i < 256; i++)
        begin
            pal_luma[i] = '0;
            pal_cb[i]   = '0;
            pal_cr[i]   = '0;
        end
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = CMD_PALETTE_WRITE;
        palette_slot = '0;
        red          = '0;
        green        = '0;
        blue         = '0;
        first_pixel  = '0;
        second_pixel = '0;
        row_typed    = 1'b0;
        row_group    = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_request(directed_rows[i]);

        // Random requests: mostly pixel pairs, palette writes now and then
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            req.cmd   = ($urandom_range(0, 99) < 20) ? CMD_PALETTE_WRITE : CMD_PIXEL_PAIR;
            req.slot  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15))
                                                    : 8'($urandom_range(0, 255));
            req.r     = 8'($urandom_range(0, 255));
            req.g     = 8'($urandom_range(0, 255));
            req.b     = 8'($urandom_range(0, 255));
            // Pull components to the rails now and then
            if ($urandom_range(0, 4) == 0)
                req.r = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
            if ($urandom_range(0, 4) == 0)
                req.g = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
            if ($urandom_range(0, 4) == 0)
                req.b = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
            req.p0    = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15))
                                                    : 8'($urandom_range(0, 255));
            req.p1    = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15))
                                                    : 8'($urandom_range(0, 255));
            req.typed = 1'b0;
            req.group = '0;
            send_request(req);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // Drain outstanding groups, then watch for strays
        while (groups_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && groups_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/p2uyvy_pkg.sv
rtl/p2uyvy_mem.sv
rtl/p2uyvy_csc.sv
rtl/palette_to_uyvy_pixel_packer.sv
bench/palette_to_uyvy_pixel_packer_tb.sv
